### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tlwt_pkg.sv
// ----------------------------------------------------------------------------
// tlwt_pkg
// Types, constants and the per-code update function of the line wrap tracker.
// ----------------------------------------------------------------------------
package tlwt_pkg;

    localparam int unsigned CFG_IDX_W    = 8;
    localparam int unsigned CFG_DATA_W   = 8;
    localparam int unsigned NO_START_CNT = 20;

    localparam logic [CFG_IDX_W-1:0] REG_COL_MAX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_MAX = 8'd1;

    localparam logic [7:0] COL_MAX_RESET = 8'd24;
    localparam logic [7:0] ROW_MAX_RESET = 8'd3;

    localparam logic [15:0] CODE_BACKSLASH  = 16'h005C;
    localparam logic [7:0]  CODE_LETTER_N   = 8'h6E;
    localparam logic [7:0]  LEAD_MIN        = 8'h80;
    localparam logic [15:0] CODE_SPACE      = 16'h0020;
    localparam logic [15:0] CODE_WIDE_SPACE = 16'h8140;

    localparam logic [15:0] NO_START_CODES [NO_START_CNT] = '{
        16'h0020, 16'h0021, 16'h002C, 16'h002E, 16'h003F, 16'h005E,
        16'h8140, 16'h8141, 16'h8142, 16'h8148, 16'h8149,
        16'h816A, 16'h8176, 16'h8178,
        16'hF040, 16'hF041, 16'hF042, 16'hF043, 16'hF044, 16'hF045
    };

    typedef enum logic [1:0] {
        ACT_TEXT     = 2'd0,
        ACT_END      = 2'd1,
        ACT_NEW_MSG  = 2'd2,
        ACT_NEW_LINE = 2'd3
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] text_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] row_count;
        logic [7:0] column;
        logic       overflow;
        logic       string_done;
    } out_item_t;

    typedef struct packed {
        logic [7:0] col_count;
        logic [7:0] row_index;
        logic       half_open;
        logic       after_wrap;
        logic       skip_next;
    } track_t;

    function automatic logic [7:0] sat_inc(logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic in_no_start(logic [15:0] code);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < NO_START_CNT; k++) begin
            if (NO_START_CODES[k] == code) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic track_t handle_code(track_t st, logic [15:0] code, logic has_next,
                                           logic [15:0] nxt, logic [7:0] col_max);
        track_t r;
        logic   is_nl;
        logic   keep_line;
        r         = st;
        is_nl     = (code == CODE_BACKSLASH) && has_next && (nxt[7:0] == CODE_LETTER_N);
        keep_line = has_next && in_no_start(nxt);
        if (st.skip_next) begin
            r.skip_next = 1'b0;
        end else if (is_nl) begin
            r.half_open = 1'b0;
            if (!(st.after_wrap && st.col_count == 8'd0)) begin
                r.row_index = sat_inc(st.row_index);
            end
            r.after_wrap = 1'b0;
            r.col_count  = 8'd0;
            r.skip_next  = 1'b1;
        end else begin
            if (code < {8'h00, LEAD_MIN}) begin
                if (!st.half_open) begin
                    r.col_count = sat_inc(st.col_count);
                    r.half_open = 1'b1;
                end else begin
                    r.half_open = 1'b0;
                end
            end else begin
                r.col_count = sat_inc(st.col_count);
            end
            if (r.col_count > col_max && !keep_line) begin
                r.half_open  = 1'b0;
                r.after_wrap = 1'b1;
                r.col_count  = 8'd0;
                r.row_index  = sat_inc(st.row_index);
            end else if (r.col_count <= 8'd1 && r.after_wrap &&
                         (code == CODE_SPACE || code == CODE_WIDE_SPACE)) begin
                r.half_open = 1'b0;
                r.col_count = 8'd0;
            end
        end
        return r;
    endfunction

endpackage

### rtl/text_line_wrap_tracker.sv
// ----------------------------------------------------------------------------
// text_line_wrap_tracker
// Follows row and column of message text in a text box, one byte per
// transaction, with line wrap, forced new lines and half-width pairing.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one item (action, text_byte) per transaction.
//   m_valid/m_ready/m_data return one result per item: row, column, overflow
//   flag and an end-of-string marker.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write col_max (index 0) and
//   row_max (index 1); other indexes are ignored. cfg_ready is always high;
//   write only while no item is in flight.
// Pipeline: an accepted item is registered in the input register; it is
//   processed from there and its result is registered in the result
//   register, which drives m_data.
// Throughput: one item per cycle while m_ready is high; the row/column state
//   feeds back through the logic between the input and result registers.
// Reset (aresetn low, synchronous): both channels empty, tracker state
//   cleared, col_max = 24, row_max = 3.
// Stall: while m_ready is low the result holds; one more item is taken into
//   the input register, after which s_ready drops until the result leaves.
// ----------------------------------------------------------------------------
module text_line_wrap_tracker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tlwt_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tlwt_pkg::out_item_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tlwt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlwt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                in_valid_reg;
    tlwt_pkg::in_item_t  in_data_reg;
    logic                out_valid_reg;
    tlwt_pkg::out_item_t out_data_reg;
    logic [7:0]          col_max_reg;
    logic [7:0]          row_max_reg;
    tlwt_pkg::track_t    trk_reg,       trk_next;
    logic [7:0]          lead_byte_reg, lead_byte_next;
    logic                lead_valid_reg, lead_valid_next;
    logic [15:0]         held_code_reg, held_code_next;
    logic                held_valid_reg, held_valid_next;
    tlwt_pkg::out_item_t out_data_next;
    logic                advance;
    logic [15:0]         code;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        trk_next        = trk_reg;
        lead_byte_next  = lead_byte_reg;
        lead_valid_next = lead_valid_reg;
        held_code_next  = held_code_reg;
        held_valid_next = held_valid_reg;
        code            = {lead_byte_reg, in_data_reg.text_byte};
        unique case (in_data_reg.action)
            tlwt_pkg::ACT_TEXT: begin
                if (!lead_valid_reg && in_data_reg.text_byte >= tlwt_pkg::LEAD_MIN) begin
                    lead_byte_next  = in_data_reg.text_byte;
                    lead_valid_next = 1'b1;
                end else begin
                    if (!lead_valid_reg) begin
                        code = {8'h00, in_data_reg.text_byte};
                    end
                    lead_valid_next = 1'b0;
                    if (held_valid_reg) begin
                        trk_next = tlwt_pkg::handle_code(trk_reg, held_code_reg, 1'b1, code,
                                                         col_max_reg);
                    end
                    held_code_next  = code;
                    held_valid_next = 1'b1;
                end
            end
            tlwt_pkg::ACT_END: begin
                if (lead_valid_reg) begin
                    code = {8'h00, lead_byte_reg};
                    if (held_valid_reg) begin
                        trk_next = tlwt_pkg::handle_code(trk_reg, held_code_reg, 1'b1, code,
                                                         col_max_reg);
                    end
                    trk_next = tlwt_pkg::handle_code(trk_next, code, 1'b0, 16'h0000,
                                                     col_max_reg);
                end else if (held_valid_reg) begin
                    trk_next = tlwt_pkg::handle_code(trk_reg, held_code_reg, 1'b0, 16'h0000,
                                                     col_max_reg);
                end
                trk_next.skip_next = 1'b0;
                lead_valid_next    = 1'b0;
                lead_byte_next     = 8'h00;
                held_valid_next    = 1'b0;
                held_code_next     = 16'h0000;
            end
            tlwt_pkg::ACT_NEW_MSG: begin
                trk_next.col_count = 8'd0;
                trk_next.row_index = 8'd0;
                trk_next.half_open = 1'b0;
                trk_next.skip_next = 1'b0;
                lead_valid_next    = 1'b0;
                lead_byte_next     = 8'h00;
                held_valid_next    = 1'b0;
                held_code_next     = 16'h0000;
            end
            tlwt_pkg::ACT_NEW_LINE: begin
                trk_next.col_count = 8'd0;
                trk_next.row_index = tlwt_pkg::sat_inc(trk_reg.row_index);
                trk_next.half_open = 1'b0;
                trk_next.skip_next = 1'b0;
                lead_valid_next    = 1'b0;
                lead_byte_next     = 8'h00;
                held_valid_next    = 1'b0;
                held_code_next     = 16'h0000;
            end
            default: begin
            end
        endcase
        out_data_next.row_count   = trk_next.row_index;
        out_data_next.column      = trk_next.col_count;
        out_data_next.overflow    = trk_next.row_index > row_max_reg;
        out_data_next.string_done = in_data_reg.action == tlwt_pkg::ACT_END;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            col_max_reg    <= tlwt_pkg::COL_MAX_RESET;
            row_max_reg    <= tlwt_pkg::ROW_MAX_RESET;
            trk_reg        <= '0;
            lead_byte_reg  <= 8'h00;
            lead_valid_reg <= 1'b0;
            held_code_reg  <= 16'h0000;
            held_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                trk_reg        <= trk_next;
                lead_byte_reg  <= lead_byte_next;
                lead_valid_reg <= lead_valid_next;
                held_code_reg  <= held_code_next;
                held_valid_reg <= held_valid_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == tlwt_pkg::REG_COL_MAX) begin
                    col_max_reg <= cfg_data;
                end else if (cfg_index == tlwt_pkg::REG_ROW_MAX) begin
                    row_max_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

### rtl/tlwt_checker.sv
// ----------------------------------------------------------------------------
// tlwt_checker
// Port-level checks for the line wrap tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlwt_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input tlwt_pkg::out_item_t m_data
);

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid right after reset")
    `ASSERT_CLK(a_ready_when_empty, aclk, aresetn, !m_valid |-> s_ready, "input stalled with empty output")
    `ASSERT_CLK(a_row0_no_ovf, aclk, aresetn, m_valid && m_data.row_count == 8'd0 |-> !m_data.overflow, "overflow flagged on row 0")

endmodule

bind text_line_wrap_tracker tlwt_checker u_tlwt_checker (.*);
